FILE: rtl/core/stg_pkg.sv
// Shared types and constants for the sine tone generator.
// No dependencies.
`timescale 1ns / 1ps

package stg_pkg;

    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;
    localparam int QUEUE_DEPTH         = 4;

    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int AMP_W        = 15;
    localparam int SINE_W       = 15;
    localparam int SAMPLE_OUT_W = 16;
    localparam int POS_W        = 32;

    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
    localparam longint unsigned Q15_MAX     = 64'd32767;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PHASE_STEP  = 2'd0,
        CFG_TONE_LENGTH = 2'd1,
        CFG_AMPLITUDE   = 2'd2
    } stg_cfg_index_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] phase_step;
        logic [POS_W-1:0]      tone_length;
        logic [AMP_W-1:0]      amplitude;
    } stg_cfg_t;

endpackage

FILE: rtl/core/stg_queue.sv
// Short flip-flop queue between the front and back parts of the tone generator.
// Depends on stg_pkg for the default depth.
`timescale 1ns / 1ps

module stg_queue
    import stg_pkg::*;
#(
    parameter int WIDTH = 45,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             out_valid,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!full || pop))
        else $error("Queue written while full.");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("Queue count beyond its depth.");

endmodule

FILE: rtl/core/stg_front.sv
// Front part of the tone generator: takes ticks, keeps the phase accumulator
// and sample counter, and queues one request per produced sample. Uses stg_pkg.
`timescale 1ns / 1ps

module stg_front
    import stg_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int ENTRY_W         = 2 + TABLE_ADDR_BITS_DEF + 1 + POS_W
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  stg_cfg_t           cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_restart,
    input  logic               queue_full,
    output logic               push,
    output logic [ENTRY_W-1:0] push_data
);

    localparam int LOOK_W = 2 + TABLE_ADDR_BITS;

    logic [PHASE_BITS-1:0] phase_acc_reg;
    logic [PHASE_BITS-1:0] phase_acc_next;
    logic [POS_W-1:0]      frame_counter_reg;
    logic [POS_W-1:0]      frame_counter_next;
    logic                  accept;
    logic [PHASE_BITS-1:0] phase_cur;
    logic [POS_W-1:0]      count_cur;
    logic [POS_W-1:0]      count_inc;
    logic                  produce;
    logic                  final_flag;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        phase_cur  = in_restart ? '0 : phase_acc_reg;
        count_cur  = in_restart ? '0 : frame_counter_reg;
        count_inc  = count_cur + 1'b1;
        produce    = (count_cur < cfg.tone_length);
        final_flag = (count_inc == cfg.tone_length);
        push       = accept && produce;
        push_data  = {final_flag, count_cur, phase_cur[PHASE_BITS-1 -: LOOK_W]};
        phase_acc_next     = phase_acc_reg;
        frame_counter_next = frame_counter_reg;
        if (accept)
        begin
            if (produce)
            begin
                phase_acc_next     = phase_cur + PHASE_BITS'(cfg.phase_step);
                frame_counter_next = count_inc;
            end
            else
            begin
                phase_acc_next     = phase_cur;
                frame_counter_next = count_cur;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg     <= '0;
            frame_counter_reg <= '0;
        end
        else
        begin
            phase_acc_reg     <= phase_acc_next;
            frame_counter_reg <= frame_counter_next;
        end
    end

    a_restart_first: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_restart && cfg.tone_length != '0)
            |-> (push && push_data[LOOK_W +: POS_W] == '0))
        else $error("Restart did not queue sample zero.");

    a_push_needs_tick: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> accept)
        else $error("Sample request queued without a tick.");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(frame_counter_reg) && $stable(phase_acc_reg))
        else $error("Oscillator state moved without a tick.");

endmodule

FILE: rtl/core/stg_back.sv
// Back part of the tone generator: quarter-wave lookup, amplitude multiply,
// sign and saturation, and the output register. Uses stg_pkg for the table.
`timescale 1ns / 1ps

module stg_back
    import stg_pkg::*;
#(
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
    parameter int ENTRY_W         = 2 + TABLE_ADDR_BITS_DEF + 1 + POS_W
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  stg_cfg_t                cfg,
    input  logic                    q_valid,
    input  logic [ENTRY_W-1:0]      q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [SAMPLE_OUT_W-1:0] out_sample,
    output logic                    out_final,
    output logic [POS_W-1:0]        out_position
);

    localparam int          IDX_W  = TABLE_ADDR_BITS + 1;
    localparam int unsigned TBL_N  = 1 << TABLE_ADDR_BITS;
    localparam int          PROD_W = AMP_W + SINE_W;
    localparam int          SAT_W  = 26;
    localparam logic signed [SAT_W-1:0] SMAX = SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SMIN = -SMAX - 1;

    logic [SINE_W-1:0] qtab [TBL_N + 1];

    // Each entry is an eleven-term Taylor series of sin in Q30 with truncated
    // products, clamped at zero and rounded to Q15.
    for (genvar k = 0; k <= TBL_N; k++)
    begin : g_table
        localparam longint unsigned THETA = (HALF_PI_Q30 * 64'(k)) >> TABLE_ADDR_BITS;
        localparam longint unsigned T2    = (THETA * THETA) >> 30;
        localparam longint unsigned TM1   = ((THETA * T2) >> 30) / 64'd6;
        localparam longint unsigned TM2   = ((TM1 * T2) >> 30) / 64'd20;
        localparam longint unsigned TM3   = ((TM2 * T2) >> 30) / 64'd42;
        localparam longint unsigned TM4   = ((TM3 * T2) >> 30) / 64'd72;
        localparam longint unsigned TM5   = ((TM4 * T2) >> 30) / 64'd110;
        localparam longint unsigned TM6   = ((TM5 * T2) >> 30) / 64'd156;
        localparam longint unsigned TM7   = ((TM6 * T2) >> 30) / 64'd210;
        localparam longint unsigned TM8   = ((TM7 * T2) >> 30) / 64'd272;
        localparam longint unsigned TM9   = ((TM8 * T2) >> 30) / 64'd342;
        localparam longint unsigned TM10  = ((TM9 * T2) >> 30) / 64'd420;
        localparam longint SUM = longint'(THETA) - longint'(TM1) + longint'(TM2)
                               - longint'(TM3) + longint'(TM4) - longint'(TM5)
                               + longint'(TM6) - longint'(TM7) + longint'(TM8)
                               - longint'(TM9) + longint'(TM10);
        localparam longint unsigned POS   = (SUM < 0) ? 64'd0 : 64'(SUM);
        localparam longint unsigned RND   = (POS * Q15_MAX + (64'd1 << 29)) >> 30;
        localparam logic [SINE_W-1:0] ENTRY =
            (RND > Q15_MAX) ? SINE_W'(Q15_MAX) : SINE_W'(RND);
        assign qtab[k] = ENTRY;
    end

    logic [1:0]                 q_quad;
    logic [TABLE_ADDR_BITS-1:0] q_addr;
    logic [IDX_W-1:0]           q_idx;

    logic                    s1_valid_reg;
    logic [SINE_W-1:0]       s1_sine_reg;
    logic                    s1_neg_reg;
    logic                    s1_final_reg;
    logic [POS_W-1:0]        s1_pos_reg;
    logic                    s2_valid_reg;
    logic [SINE_W-1:0]       s2_mag_reg;
    logic                    s2_neg_reg;
    logic                    s2_final_reg;
    logic [POS_W-1:0]        s2_pos_reg;
    logic                    out_valid_reg;
    logic [SAMPLE_OUT_W-1:0] out_sample_reg;
    logic                    out_final_reg;
    logic [POS_W-1:0]        out_pos_reg;

    logic                    adv3;
    logic                    adv2;
    logic                    adv1;
    logic [PROD_W-1:0]       product;
    logic signed [SAT_W-1:0] signed_val;
    logic signed [SAT_W-1:0] sat_val;

    assign q_quad = q_data[TABLE_ADDR_BITS +: 2];
    assign q_addr = q_data[TABLE_ADDR_BITS-1:0];
    assign q_idx  = q_quad[0] ? (IDX_W'(TBL_N) - {1'b0, q_addr}) : {1'b0, q_addr};

    assign adv3  = !out_valid_reg || out_ready;
    assign adv2  = !s2_valid_reg || adv3;
    assign adv1  = !s1_valid_reg || adv2;
    assign q_pop = q_valid && adv1;

    always_comb
    begin
        product    = PROD_W'(cfg.amplitude) * PROD_W'(s1_sine_reg);
        signed_val = s2_neg_reg ? -SAT_W'(s2_mag_reg) : SAT_W'(s2_mag_reg);
        sat_val    = signed_val;
        if (signed_val > SMAX)
        begin
            sat_val = SMAX;
        end
        else if (signed_val < SMIN)
        begin
            sat_val = SMIN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                s1_valid_reg <= q_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && q_valid)
        begin
            s1_sine_reg  <= qtab[q_idx];
            s1_neg_reg   <= q_quad[1];
            s1_final_reg <= q_data[ENTRY_W-1];
            s1_pos_reg   <= q_data[2 + TABLE_ADDR_BITS +: POS_W];
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_mag_reg   <= product[PROD_W-1 -: SINE_W];
            s2_neg_reg   <= s1_neg_reg;
            s2_final_reg <= s1_final_reg;
            s2_pos_reg   <= s1_pos_reg;
        end
        if (adv3 && s2_valid_reg)
        begin
            out_sample_reg <= sat_val[SAMPLE_OUT_W-1:0];
            out_final_reg  <= s2_final_reg;
            out_pos_reg    <= s2_pos_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_sample   = out_sample_reg;
    assign out_final    = out_final_reg;
    assign out_position = out_pos_reg;

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("Queue popped while empty.");

endmodule

FILE: rtl/core/sine_tone_generator.sv
// Top level of the sine tone generator: configuration registers, front part,
// request queue and back part. Depends on stg_pkg, stg_front, stg_queue, stg_back.
//
//   Channel   Direction  Handshake                  Payload
//   s_axis    in         s_axis_tvalid/tready       tdata[0] restart
//   m_axis    out        m_axis_tvalid/tready       tdata sample_out, position; tlast final_frame
//   cfg       in         cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One tick is accepted per cycle while the queue is not full; a sample passes through
// the queue, table read, multiply and output registers after its tick. The front stalls
// only when the four-entry queue is full, so a stalled output holds up ticks once it fills.
// Reset clears phase, sample count and all configuration registers to zero.
// cfg_ready is always high; writes to an unused index are ignored.
`timescale 1ns / 1ps

module sine_tone_generator
    import stg_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [7:0]             s_axis_tdata,   // [0] restart, [7:1] zero
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [47:0]            m_axis_tdata,   // [15:0] sample_out, [47:16] position
    output logic                   m_axis_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int ENTRY_W = 2 + TABLE_ADDR_BITS + 1 + POS_W;

    stg_cfg_t cfg_reg;
    logic     q_push;
    logic [ENTRY_W-1:0] q_push_data;
    logic     q_full;
    logic     q_pop;
    logic     q_valid;
    logic [ENTRY_W-1:0] q_data;
    logic [SAMPLE_OUT_W-1:0] sample;
    logic [POS_W-1:0]        position;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (stg_cfg_index_t'(cfg_index))
                CFG_PHASE_STEP:  cfg_reg.phase_step  <= cfg_data;
                CFG_TONE_LENGTH: cfg_reg.tone_length <= cfg_data[POS_W-1:0];
                CFG_AMPLITUDE:   cfg_reg.amplitude   <= cfg_data[AMP_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    stg_front #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .ENTRY_W         (ENTRY_W)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_restart (s_axis_tdata[0]),
        .queue_full (q_full),
        .push       (q_push),
        .push_data  (q_push_data)
    );

    stg_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .out_valid (q_valid),
        .out_data  (q_data)
    );

    stg_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS),
        .ENTRY_W         (ENTRY_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_sample   (sample),
        .out_final    (m_axis_tlast),
        .out_position (position)
    );

    assign m_axis_tdata = {position, sample};

endmodule
